// ----- src/bas_pkg.sv -----
// bas_pkg: shared types, constants and the palette function of the screen renderer
// used by every module of the block but bas_ram; depends on nothing
`default_nettype none

package bas_pkg;

    // store layout
    localparam int unsigned ADDR_W      = 13;
    localparam int unsigned STORE_SIZE  = 6912;
    localparam int unsigned BITMAP_SIZE = 6144;
    localparam logic [ADDR_W-1:0] ATTR_BASE = 13'd6144;

    // item kinds carried in tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // configuration register indexes
    localparam logic CFG_NORMAL_LEVEL = 1'b0;
    localparam logic CFG_BRIGHT_LEVEL = 1'b1;

    // reset levels
    localparam logic [7:0] NORMAL_LEVEL_RST = 8'd215;
    localparam logic [7:0] BRIGHT_LEVEL_RST = 8'd255;

    // attribute byte fields
    localparam int unsigned ATTR_FLASH_BIT  = 7;
    localparam int unsigned ATTR_BRIGHT_BIT = 6;
    localparam logic [7:0]  ALPHA           = 8'hff;

    // command passed from the front end to the back end
    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] addr;       // store address or bitmap cell
        logic [7:0]        data;
        logic [ADDR_W-1:0] attr_addr;
        logic [4:0]        column;
        logic [7:0]        y;
        logic              phase;
    } t_cmd;

    // palette index to ARGB: bit 0 blue, bit 1 red, bit 2 green
    function automatic logic [31:0] palette_color(input logic [2:0] index,
                                                  input logic [7:0] level);
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        red   = index[1] ? level : 8'd0;
        green = index[2] ? level : 8'd0;
        blue  = index[0] ? level : 8'd0;
        return {ALPHA, red, green, blue};
    endfunction

endpackage

`default_nettype wire

// ----- src/bitmap_attribute_screen_renderer.sv -----
// bitmap_attribute_screen_renderer: top level of the bitmap/attribute screen renderer
// depends on bas_pkg, bas_front, bas_cmd_fifo, bas_back and bas_ram
//
// channel   direction  handshake                       payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tuser op, tdata store and cell fields
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata pixel x, y, color; tlast
// cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// the back end does a write transaction as it pops it; a render reads the bitmap
// byte and then the attribute byte through the single read port of the screen store,
// sets up the colors and emits eight pixels, which back-pressure on m_axis can stall.
// the command queue lets input transactions land while the back end is busy.
// synchronous active-low reset clears control and the queue and returns the levels
// to their reset values; the store itself is not cleared. o_cfg_ready is always high.
`default_nettype none

module bitmap_attribute_screen_renderer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // store_address, store_data, cell_index, flash_phase
    input  wire logic        s_axis_tuser,  // op
    // pixel results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // pixel_x, pixel_y, pixel_color
    output logic             m_axis_tlast,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import bas_pkg::*;

    t_cmd       front_cmd;
    logic       front_keep;
    logic       fifo_full;
    logic       fifo_valid;
    logic       fifo_pop;
    t_cmd       fifo_cmd;
    logic       accept;
    logic [7:0] r_normal_level;
    logic [7:0] r_bright_level;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [31:0] pixel_color;

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_level <= NORMAL_LEVEL_RST;
            r_bright_level <= BRIGHT_LEVEL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NORMAL_LEVEL: r_normal_level <= i_cfg_data;
                CFG_BRIGHT_LEVEL: r_bright_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end
    bas_front u_front (
        .i_op            (s_axis_tuser),
        .i_store_address (s_axis_tdata[12:0]),
        .i_store_data    (s_axis_tdata[20:13]),
        .i_cell_index    (s_axis_tdata[33:21]),
        .i_flash_phase   (s_axis_tdata[34]),
        .o_cmd           (front_cmd),
        .o_keep          (front_keep)
    );

    // command queue
    bas_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && front_keep),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_cmd   (fifo_cmd),
        .o_valid (fifo_valid)
    );

    // back end
    bas_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (fifo_cmd),
        .i_cmd_valid    (fifo_valid),
        .o_pop          (fifo_pop),
        .i_normal_level (r_normal_level),
        .i_bright_level (r_bright_level),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_pixel_color  (pixel_color),
        .o_last_pixel   (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_color, pixel_y, pixel_x};

endmodule

`default_nettype wire

// ----- src/bas_ram.sv -----
// bas_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module bas_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 6912
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/bas_front.sv -----
// bas_front: classifies input items, flags out-of-range ones to be dropped and builds commands
// depends on bas_pkg
`default_nettype none

module bas_front (
    input  wire logic                      i_op,
    input  wire logic [bas_pkg::ADDR_W-1:0] i_store_address,
    input  wire logic [7:0]                i_store_data,
    input  wire logic [bas_pkg::ADDR_W-1:0] i_cell_index,
    input  wire logic                      i_flash_phase,
    output bas_pkg::t_cmd                  o_cmd,
    output logic                           o_keep
);
    import bas_pkg::*;

    logic [7:0] y;
    logic [4:0] column;

    // de-interleave the row and locate the attribute byte
    always_comb begin
        column = i_cell_index[4:0];
        y      = {i_cell_index[12:11], i_cell_index[7:5], i_cell_index[10:8]};
    end

    // command build and range check
    always_comb begin
        o_cmd.is_write  = (i_op == OP_WRITE);
        o_cmd.addr      = (i_op == OP_WRITE) ? i_store_address : i_cell_index;
        o_cmd.data      = i_store_data;
        o_cmd.attr_addr = ATTR_BASE + {3'd0, y[7:3], column};
        o_cmd.column    = column;
        o_cmd.y         = y;
        o_cmd.phase     = i_flash_phase;
        if (i_op == OP_WRITE) begin
            o_keep = ({19'd0, i_store_address} < STORE_SIZE);
        end else begin
            o_keep = ({19'd0, i_cell_index} < BITMAP_SIZE);
        end
    end

endmodule

`default_nettype wire

// ----- src/bas_cmd_fifo.sv -----
// bas_cmd_fifo: short register queue of commands between front and back end
// depends on bas_pkg
`default_nettype none

module bas_cmd_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bas_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output bas_pkg::t_cmd      o_cmd,
    output logic               o_valid
);
    import bas_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/bas_back.sv -----
// bas_back: executes queued commands: store writes, two store reads per render,
// and eight pixels through an output register; depends on bas_pkg and bas_ram
`default_nettype none

module bas_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bas_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_pop,
    input  wire logic [7:0]    i_normal_level,
    input  wire logic [7:0]    i_bright_level,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_pixel_x,
    output logic [7:0]         o_pixel_y,
    output logic [31:0]        o_pixel_color,
    output logic               o_last_pixel
);
    import bas_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BITS = 2'd1;
    localparam logic [1:0] ST_ATTR = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ADDR_W-1:0] r_attr_addr;
    logic [4:0]        r_column;
    logic [7:0]        r_y;
    logic              r_phase;
    logic [7:0]        r_bits;
    logic [2:0]        r_ink_idx;
    logic [2:0]        r_paper_idx;
    logic [7:0]        r_level;
    logic [2:0]        r_pix;
    logic              r_out_valid;
    logic [7:0]        r_out_x;
    logic [7:0]        r_out_y;
    logic [31:0]       r_out_color;
    logic              r_out_last;

    logic              ram_we;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;
    logic              out_free;
    logic              emit;
    logic              swap;

    // screen store
    bas_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (i_cmd.addr),
        .i_wr_data (i_cmd.data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // command pop and store access
    always_comb begin
        o_pop       = (r_state == ST_IDLE) && i_cmd_valid;
        ram_we      = o_pop && i_cmd.is_write;
        ram_rd_en   = (o_pop && !i_cmd.is_write) || (r_state == ST_BITS);
        ram_rd_addr = (r_state == ST_IDLE) ? i_cmd.addr : r_attr_addr;
        out_free    = !r_out_valid || i_ready;
        emit        = (r_state == ST_EMIT) && out_free;
        swap        = ram_rd_data[ATTR_FLASH_BIT] && r_phase;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && !i_cmd.is_write) begin
                    n_state = ST_BITS;
                end
            end
            ST_BITS: n_state = ST_ATTR;
            ST_ATTR: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit && (r_pix == 3'd7)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pix       <= 3'd0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_ATTR) begin
                r_pix <= 3'd0;
            end else if (emit) begin
                r_pix <= r_pix + 3'd1;
            end
        end
    end

    // render context capture
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_attr_addr <= i_cmd.attr_addr;
            r_column    <= i_cmd.column;
            r_y         <= i_cmd.y;
            r_phase     <= i_cmd.phase;
        end
        if (r_state == ST_BITS) begin
            r_bits <= ram_rd_data;
        end else if (emit) begin
            r_bits <= {r_bits[6:0], 1'b0};
        end
        // set bits show ink unless flash inverts them
        if (r_state == ST_ATTR) begin
            r_ink_idx   <= swap ? ram_rd_data[5:3] : ram_rd_data[2:0];
            r_paper_idx <= swap ? ram_rd_data[2:0] : ram_rd_data[5:3];
            r_level     <= ram_rd_data[ATTR_BRIGHT_BIT] ? i_bright_level
                                                        : i_normal_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x     <= {r_column, r_pix};
            r_out_y     <= r_y;
            r_out_color <= palette_color(r_bits[7] ? r_ink_idx : r_paper_idx, r_level);
            r_out_last  <= (r_pix == 3'd7);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

`default_nettype wire

// ----- sim/tb_bitmap_attribute_screen_renderer.sv -----
// tb_bitmap_attribute_screen_renderer: self-checking bench for the screen renderer
// drives store writes, cell renders and level writes, predicts every pixel in the
// bench and compares each output transaction; depends on bas_pkg and the block top
`timescale 1ns / 100ps

module tb_bitmap_attribute_screen_renderer;
    import bas_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;     // several renders' worth of back-end cycles
    localparam int RANDOM_ITEMS = 280;

    // one input item as the block sees it
    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [ADDR_W-1:0] cell_no;
        logic              phase;
    } screen_item_t;

    // one expected pixel
    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] color;
        logic        last;
    } pixel_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // store_address, store_data, cell_index, flash_phase
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // pixel_x, pixel_y, pixel_color
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = '0;

    // bench copy of the block state
    logic [7:0] shadow_store [0:STORE_SIZE-1];
    logic [7:0] normal_lvl = NORMAL_LEVEL_RST;
    logic [7:0] bright_lvl = BRIGHT_LEVEL_RST;

    pixel_t expected_pixels [$];
    int     painted_cells [$];   // cells whose bitmap and attribute bytes are written
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     steady = 1'b0;       // no idling on either side while set

    bitmap_attribute_screen_renderer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock and cycle counter
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t timeout, %0d pixels still expected", $time, expected_pixels.size());
        $display("bitmap_attribute_screen_renderer test failed");
        $finish;
    end

    // pixel sink back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 21);
    end

    // palette index to ARGB, blue from bit 0, red from bit 1, green from bit 2
    function automatic logic [31:0] argb_of(input logic [2:0] idx, input logic [7:0] lvl);
        return {8'hff, idx[1] ? lvl : 8'h00, idx[2] ? lvl : 8'h00, idx[0] ? lvl : 8'h00};
    endfunction

    // update the bench store or queue the eight pixels of a render
    function automatic void predict_pixels(input screen_item_t it);
        logic [7:0]        row;
        logic [7:0]        bits;
        logic [7:0]        attr;
        logic [7:0]        lvl;
        logic [ADDR_W-1:0] attr_addr;
        logic [31:0]       ink;
        logic [31:0]       paper;
        logic              swap;
        pixel_t            px;
        if (it.op == OP_WRITE) begin
            if (it.addr < STORE_SIZE) begin
                shadow_store[it.addr] = it.data;
            end
            return;
        end
        if (it.cell_no >= BITMAP_SIZE) return;
        row       = {it.cell_no[12:11], it.cell_no[7:5], it.cell_no[10:8]};
        attr_addr = ATTR_BASE + {3'd0, row[7:3], it.cell_no[4:0]};
        bits      = shadow_store[it.cell_no];
        attr      = shadow_store[attr_addr];
        lvl       = attr[ATTR_BRIGHT_BIT] ? bright_lvl : normal_lvl;
        ink       = argb_of(attr[2:0], lvl);
        paper     = argb_of(attr[5:3], lvl);
        swap      = attr[ATTR_FLASH_BIT] & it.phase;
        for (int j = 0; j < 8; j++) begin
            px.x     = {it.cell_no[4:0], 3'(j)};
            px.y     = row;
            px.color = (bits[7-j] ^ swap) ? ink : paper;
            px.last  = (j == 7);
            expected_pixels.push_back(px);
        end
    endfunction

    // compare every pixel transaction with the oldest expectation
    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected pixel: expected none, actual tdata %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.x) begin
                    mismatch_count++;
                    $display("%0t pixel_x: expected %0d, actual %0d",
                             $time, want.x, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[15:8] !== want.y) begin
                    mismatch_count++;
                    $display("%0t pixel_y: expected %0d, actual %0d",
                             $time, want.y, m_axis_tdata[15:8]);
                end
                if (m_axis_tdata[47:16] !== want.color) begin
                    mismatch_count++;
                    $display("%0t pixel_color: expected %h, actual %h",
                             $time, want.color, m_axis_tdata[47:16]);
                end
                if (m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    $display("%0t last_pixel: expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // one input transaction, with a random idle gap ahead of it
    task automatic send_item(input screen_item_t it);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < 21) gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {5'd0, it.phase, it.cell_no, it.data, it.addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixels(it);
        @(negedge i_clk);
    endtask

    task automatic send_write(input int addr, input logic [7:0] data);
        screen_item_t it;
        it.op      = OP_WRITE;
        it.addr    = addr[ADDR_W-1:0];
        it.data    = data;
        it.cell_no = ADDR_W'($urandom());
        it.phase   = 1'($urandom());
        send_item(it);
    endtask

    task automatic send_render(input int cell_no, input logic phase);
        screen_item_t it;
        it.op      = OP_RENDER;
        it.addr    = ADDR_W'($urandom());
        it.data    = 8'($urandom());
        it.cell_no = cell_no[ADDR_W-1:0];
        it.phase   = phase;
        send_item(it);
    endtask

    // store address of the attribute byte for a bitmap cell
    function automatic int attr_addr_of(input int cell_no);
        logic [12:0] c;
        c = cell_no[12:0];
        return BITMAP_SIZE + {c[12:11], c[7:5]} * 32 + c[4:0];
    endfunction

    // stop sending and wait until every pixel is out and the back end settles
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    // one level register write while the block is idle
    task automatic write_level(input logic idx, input logic [7:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_NORMAL_LEVEL) normal_lvl = value;
        else bright_lvl = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // corner cells, flash swap, bright, ignored writes and renders
    task automatic test_directed_cases();
        send_write(0, 8'h81);
        send_write(BITMAP_SIZE, 8'hc7);          // flash, bright, black paper, white ink
        painted_cells.push_back(0);
        send_render(0, 1'b0);
        send_render(0, 1'b1);                    // flash inverts
        send_write(BITMAP_SIZE - 1, 8'hff);
        send_write(STORE_SIZE - 1, 8'h38);       // normal, white paper, black ink
        painted_cells.push_back(BITMAP_SIZE - 1);
        send_render(BITMAP_SIZE - 1, 1'b1);      // phase without flash changes nothing
        send_write(STORE_SIZE - 1, 8'h00);
        send_render(BITMAP_SIZE - 1, 1'b0);
        send_write(STORE_SIZE, 8'hff);           // beyond the store, dropped
        send_write(8191, 8'hff);
        send_render(BITMAP_SIZE, 1'b1);          // beyond the bitmap, dropped
        send_render(8191, 1'b0);
        send_write(0, 8'h00);
        send_render(0, 1'b1);                    // all paper, flashed to ink
        send_write(attr_addr_of(1234), 8'h6a);
        send_write(1234, 8'h5a);
        painted_cells.push_back(1234);
        send_render(1234, 1'b0);
        send_render(0, 1'b0);
    endtask

    // level settings including the extremes, each checked with bright and normal cells
    task automatic test_level_registers();
        logic [7:0] norm_set [6];
        logic [7:0] brt_set [6];
        norm_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom()), NORMAL_LEVEL_RST};
        brt_set  = '{8'd255, 8'd0, 8'd0, 8'd255, 8'($urandom()), BRIGHT_LEVEL_RST};
        for (int k = 0; k < 6; k++) begin
            write_level(CFG_NORMAL_LEVEL, norm_set[k]);
            write_level(CFG_BRIGHT_LEVEL, brt_set[k]);
            send_write(0, 8'hf0);
            send_write(BITMAP_SIZE, 8'h4e);      // bright, blue paper, yellow ink
            send_render(0, 1'b0);
            send_write(BITMAP_SIZE, 8'h8b);      // flashing, normal
            send_render(0, 1'(k));
        end
    endtask

    // random traffic: mostly paint-then-render sequences, some noise
    task automatic test_random_traffic();
        int  sent;
        int  cell_no;
        int  addr;
        int  pick;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        steady = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 70) steady = 1'b0;
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                // paint a fresh cell and show it
                cell_no = $urandom_range(BITMAP_SIZE - 1);
                send_write(cell_no, 8'($urandom()));
                send_write(attr_addr_of(cell_no), 8'($urandom()));
                painted_cells.push_back(cell_no);
                send_render(cell_no, 1'($urandom()));
                sent += 3;
            end else if (pick < 75) begin
                cell_no = painted_cells[$urandom_range(painted_cells.size() - 1)];
                send_render(cell_no, 1'($urandom()));
                sent++;
            end else if (pick < 85) begin
                // stray write anywhere, left unrendered
                addr = $urandom_range(8191);
                send_write(addr, 8'($urandom()));
                if (addr < STORE_SIZE) sent++;
            end else if (pick < 90) begin
                send_render($urandom_range(8191, BITMAP_SIZE), 1'($urandom()));
            end else begin
                // recolor a painted cell, then show it
                cell_no = painted_cells[$urandom_range(painted_cells.size() - 1)];
                send_write(attr_addr_of(cell_no), 8'($urandom()));
                send_render(cell_no, 1'($urandom()));
                sent += 2;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_level_registers();
        write_level(CFG_NORMAL_LEVEL, 8'($urandom()));
        write_level(CFG_BRIGHT_LEVEL, 8'($urandom()));
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("bitmap_attribute_screen_renderer test passed");
        end else begin
            $display("bitmap_attribute_screen_renderer test failed");
        end
        $finish;
    end

endmodule
